@@ rtl/maze_backtracker_step_defines.svh @@
`ifndef MAZE_BACKTRACKER_STEP_DEFINES_SVH
`define MAZE_BACKTRACKER_STEP_DEFINES_SVH

// property that holds on every clock edge out of reset
`define MBS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mbs_pkg.sv @@
`default_nettype none

package mbs_pkg;

	localparam int MAX_SIDE = 64;
	localparam int COORD_W  = $clog2(MAX_SIDE);
	localparam int CELL_W   = 2 * COORD_W;
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int CNT_W    = CELL_W + 1;
	localparam int N_W      = COORD_W + 1;
	localparam int SIDE_W   = 7;
	localparam int RND_W    = 16;
	localparam int OUT_W    = 6;
	localparam int DIR_W    = 2;
	localparam int NBR      = 4;
	localparam int SIDE_RESET = 50;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CELL_W-1:0]  cell_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [N_W-1:0]     n_t;
	typedef logic [SIDE_W-1:0]  side_t;
	typedef logic [OUT_W-1:0]   ocoord_t;
	typedef logic [DIR_W-1:0]   dir_t;

	localparam dir_t DIR_UP    = 2'd0;
	localparam dir_t DIR_DOWN  = 2'd1;
	localparam dir_t DIR_LEFT  = 2'd2;
	localparam dir_t DIR_RIGHT = 2'd3;

	typedef struct packed {
		logic clr;
		logic load;
		logic look;
		dir_t idx;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic empty;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/mbs_if.sv @@
`default_nettype none

interface mbs_rand_if;
	logic                        valid;
	logic                        ready;
	logic [mbs_pkg::RND_W-1:0]   random;

	modport source (output valid, output random, input ready);
	modport sink   (input valid, input random, output ready);
endinterface

interface mbs_res_if;
	logic              valid;
	logic              ready;
	logic              finished;
	logic              carved;
	mbs_pkg::ocoord_t  from_row;
	mbs_pkg::ocoord_t  from_col;
	mbs_pkg::dir_t     carve_dir;
	mbs_pkg::ocoord_t  cur_row;
	mbs_pkg::ocoord_t  cur_col;

	modport source (output valid, output finished, output carved, output from_row,
		output from_col, output carve_dir, output cur_row, output cur_col, input ready);
	modport sink   (input valid, input finished, input carved, input from_row,
		input from_col, input carve_dir, input cur_row, input cur_col, output ready);
endinterface

interface mbs_cfg_if;
	logic            valid;
	logic            ready;
	mbs_pkg::side_t  side;

	modport source (output valid, output side, input ready);
	modport sink   (input valid, input side, output ready);
endinterface

`default_nettype wire

@@ rtl/mbs_ram.sv @@
`default_nettype none

module mbs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/mbs_ctrl.sv @@
`default_nettype none

module mbs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mbs_pkg::sts_t sts,
	input  wire logic          in_valid,
	output logic               in_ready,
	output mbs_pkg::cmd_t      cmd
);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOK   = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	logic [1:0]    state_q;
	logic [1:0]    state_d;
	mbs_pkg::dir_t look_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.idx  = look_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.empty ? ST_DECIDE : ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (look_q == mbs_pkg::DIR_RIGHT) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			look_q  <= mbs_pkg::DIR_UP;
		end else begin
			state_q <= state_d;
			if (cmd.look) begin
				look_q <= look_q + mbs_pkg::dir_t'(1);
			end else begin
				look_q <= mbs_pkg::DIR_UP;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/mbs_datapath.sv @@
`default_nettype none
`include "maze_backtracker_step_defines.svh"

module mbs_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mbs_pkg::cmd_t               cmd,
	output mbs_pkg::sts_t                    sts,
	input  wire logic [mbs_pkg::RND_W-1:0]   rnd,
	mbs_cfg_if.sink                          cfg,
	mbs_res_if.source                        result
);

	mbs_pkg::side_t             side_q;
	mbs_pkg::cell_t             cur_q;
	mbs_pkg::cnt_t              cnt_q;
	logic [mbs_pkg::RND_W-1:0]  rnd_q;
	logic [1:0]                 rem3_q;
	logic [2:0]                 free_q;
	mbs_pkg::cell_t             clr_q;
	logic                       out_valid_q;
	logic                       out_finished_q;
	logic                       out_carved_q;
	mbs_pkg::ocoord_t           out_from_row_q;
	mbs_pkg::ocoord_t           out_from_col_q;
	mbs_pkg::dir_t              out_dir_q;
	mbs_pkg::ocoord_t           out_cur_row_q;
	mbs_pkg::ocoord_t           out_cur_col_q;

	mbs_pkg::coord_t            row;
	mbs_pkg::coord_t            col;
	mbs_pkg::n_t                n_eff;
	mbs_pkg::n_t                rx;
	mbs_pkg::n_t                cx;
	logic [mbs_pkg::NBR-1:0]    ingrid;
	logic [mbs_pkg::NBR-1:0]    cand;
	mbs_pkg::cell_t             nb_cell [mbs_pkg::NBR];
	logic                       vis_we;
	mbs_pkg::cell_t             vis_waddr;
	logic                       vis_rd;
	logic                       stk_we;
	logic                       stk_re;
	mbs_pkg::cnt_t              top_idx;
	mbs_pkg::cell_t             stk_rd;
	mbs_pkg::cell_t             pop_cell;
	mbs_pkg::cell_t             next_cell;
	logic [2:0]                 num;
	logic [1:0]                 pick;
	mbs_pkg::dir_t              sel;
	logic                       any;
	logic                       empty;
	logic                       push_ok;

	function automatic logic [1:0] mod3(input logic [mbs_pkg::RND_W-1:0] v);
		logic [4:0] s;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < mbs_pkg::RND_W / 2; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

	assign row   = cur_q[mbs_pkg::CELL_W-1:mbs_pkg::COORD_W];
	assign col   = cur_q[mbs_pkg::COORD_W-1:0];
	assign rx    = {1'b0, row};
	assign cx    = {1'b0, col};
	assign empty = (cnt_q == '0);

	always_comb begin
		if (side_q == '0) begin
			n_eff = mbs_pkg::n_t'(1);
		end else if (int'(side_q) > mbs_pkg::MAX_SIDE) begin
			n_eff = mbs_pkg::n_t'(mbs_pkg::MAX_SIDE);
		end else begin
			n_eff = mbs_pkg::n_t'(side_q);
		end
	end

	assign ingrid[mbs_pkg::DIR_UP] = (row != '0) && ((rx - mbs_pkg::n_t'(1)) < n_eff)
		&& (cx < n_eff);
	assign ingrid[mbs_pkg::DIR_DOWN] = ((rx + mbs_pkg::n_t'(1)) < n_eff) && (cx < n_eff);
	assign ingrid[mbs_pkg::DIR_LEFT] = (col != '0) && ((cx - mbs_pkg::n_t'(1)) < n_eff)
		&& (rx < n_eff);
	assign ingrid[mbs_pkg::DIR_RIGHT] = ((cx + mbs_pkg::n_t'(1)) < n_eff) && (rx < n_eff);

	assign nb_cell[mbs_pkg::DIR_UP]    = {row - mbs_pkg::coord_t'(1), col};
	assign nb_cell[mbs_pkg::DIR_DOWN]  = {row + mbs_pkg::coord_t'(1), col};
	assign nb_cell[mbs_pkg::DIR_LEFT]  = {row, col - mbs_pkg::coord_t'(1)};
	assign nb_cell[mbs_pkg::DIR_RIGHT] = {row, col + mbs_pkg::coord_t'(1)};

	// visited map: clearing pass, mark current cell, neighbour lookups
	assign vis_we    = cmd.clr || (cmd.look && (cmd.idx == mbs_pkg::DIR_UP));
	assign vis_waddr = cmd.clr ? clr_q : cur_q;

	mbs_ram #(
		.WIDTH (1),
		.DEPTH (mbs_pkg::CELLS)
	) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (!cmd.clr),
		.re    (cmd.look),
		.raddr (nb_cell[cmd.idx]),
		.rdata (vis_rd)
	);

	// path stack: top prefetched during the first lookup
	assign top_idx = cnt_q - mbs_pkg::cnt_t'(1);
	assign push_ok = (cnt_q < mbs_pkg::cnt_t'(mbs_pkg::CELLS));
	assign stk_re  = cmd.look && (cmd.idx == mbs_pkg::DIR_UP);
	assign stk_we  = cmd.commit && !empty && any && push_ok;

	mbs_ram #(
		.WIDTH (mbs_pkg::CELL_W),
		.DEPTH (mbs_pkg::CELLS)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (cnt_q[mbs_pkg::CELL_W-1:0]),
		.wdata (cur_q),
		.re    (stk_re),
		.raddr (top_idx[mbs_pkg::CELL_W-1:0]),
		.rdata (stk_rd)
	);

	// bottom entry is the origin and is never written
	assign pop_cell = (cnt_q == mbs_pkg::cnt_t'(1)) ? '0 : stk_rd;

	assign cand = ingrid & {!vis_rd, free_q};
	assign any  = |cand;
	assign num  = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);

	always_comb begin
		case (num)
			3'd2:    pick = {1'b0, rnd_q[0]};
			3'd3:    pick = rem3_q;
			3'd4:    pick = rnd_q[1:0];
			default: pick = 2'd0;
		endcase
	end

	always_comb begin
		logic [1:0] seen;
		seen = '0;
		sel  = mbs_pkg::DIR_UP;
		for (int i = 0; i < mbs_pkg::NBR; i++) begin
			if (cand[i]) begin
				if (seen == pick) begin
					sel = mbs_pkg::dir_t'(i);
				end
				seen = seen + 2'd1;
			end
		end
	end

	always_comb begin
		if (empty) begin
			next_cell = cur_q;
		end else if (any) begin
			next_cell = nb_cell[sel];
		end else begin
			next_cell = pop_cell;
		end
	end

	assign sts.clr_last = (clr_q == '1);
	assign sts.empty    = empty;
	assign sts.out_busy = out_valid_q && !result.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rnd_q <= rnd;
		end
		if (cmd.look) begin
			rem3_q <= mod3(rnd_q);
			case (cmd.idx)
				mbs_pkg::DIR_DOWN:  free_q[0] <= !vis_rd;
				mbs_pkg::DIR_LEFT:  free_q[1] <= !vis_rd;
				mbs_pkg::DIR_RIGHT: free_q[2] <= !vis_rd;
				default:            free_q    <= free_q;
			endcase
		end
		if (cmd.commit) begin
			out_finished_q <= empty;
			out_carved_q   <= !empty && any;
			out_from_row_q <= mbs_pkg::ocoord_t'(row);
			out_from_col_q <= mbs_pkg::ocoord_t'(col);
			out_dir_q      <= (!empty && any) ? sel : mbs_pkg::DIR_UP;
			out_cur_row_q  <= mbs_pkg::ocoord_t'(next_cell[mbs_pkg::CELL_W-1:mbs_pkg::COORD_W]);
			out_cur_col_q  <= mbs_pkg::ocoord_t'(next_cell[mbs_pkg::COORD_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q      <= mbs_pkg::side_t'(mbs_pkg::SIDE_RESET);
			cur_q       <= '0;
			cnt_q       <= mbs_pkg::cnt_t'(1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				side_q <= cfg.side;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + mbs_pkg::cell_t'(1);
			end
			if (cmd.commit && !empty) begin
				cur_q <= next_cell;
				if (!any) begin
					cnt_q <= top_idx;
				end else if (push_ok) begin
					cnt_q <= cnt_q + mbs_pkg::cnt_t'(1);
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.finished  = out_finished_q;
	assign result.carved    = out_carved_q;
	assign result.from_row  = out_from_row_q;
	assign result.from_col  = out_from_col_q;
	assign result.carve_dir = out_dir_q;
	assign result.cur_row   = out_cur_row_q;
	assign result.cur_col   = out_cur_col_q;

	`MBS_ASSERT(a_commit_slot_free, !cmd.commit || !(out_valid_q && !result.ready), "commit while result held")
	`MBS_ASSERT_NEXT(a_commit_shows, cmd.commit, result.valid, "committed step not presented")
	`MBS_ASSERT_NEXT(a_push_count, stk_we, cnt_q == $past(cnt_q) + mbs_pkg::cnt_t'(1), "push count")
	`MBS_ASSERT_NEXT(a_pop_count, cmd.commit && !empty && !any, cnt_q == $past(top_idx), "pop count")
	`MBS_ASSERT(a_cnt_bound, cnt_q <= mbs_pkg::cnt_t'(mbs_pkg::CELLS), "stack count overflow")

endmodule

`default_nettype wire

@@ rtl/maze_backtracker_step.sv @@
`default_nettype none

// randomized depth-first maze walker: each step beat carries a random word and
// yields one result beat (carve, backtrack or finished). after reset a clearing
// pass zeroes every cell of the visited map with step.ready low; cfg writes are
// taken at any time. a step runs accept, four neighbour lookups and decide, or
// accept and decide once finished; the lookups share the single read port of
// the visited-map memory, which looks up one neighbour per cycle. the result
// register lets the next step beat be accepted while a result is still waiting.
module maze_backtracker_step (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mbs_cfg_if.sink    cfg,
	mbs_rand_if.sink   step,
	mbs_res_if.source  result
);

	mbs_pkg::cmd_t cmd;
	mbs_pkg::sts_t sts;

	mbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.in_valid (step.valid),
		.in_ready (step.ready),
		.cmd      (cmd)
	);

	mbs_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.rnd    (step.random),
		.cfg    (cfg),
		.result (result)
	);

endmodule

`default_nettype wire

@@ verif/tb_maze_backtracker_step.sv @@
`timescale 1ns / 1ps

module tb_maze_backtracker_step;

	localparam int IDLE_LIMIT = 20000;

	typedef logic [mbs_pkg::RND_W-1:0] word_t;

	typedef struct packed {
		logic             finished;
		logic             carved;
		mbs_pkg::ocoord_t from_row;
		mbs_pkg::ocoord_t from_col;
		mbs_pkg::dir_t    carve_dir;
		mbs_pkg::ocoord_t cur_row;
		mbs_pkg::ocoord_t cur_col;
	} walk_beat_t;

	class maze_walk_board;
		bit             visited[mbs_pkg::CELLS];
		int             path[mbs_pkg::CELLS];
		int             depth;
		int             here;
		mbs_pkg::side_t side_reg;
		walk_beat_t     pending[$];
		int             errors;

		function new();
			foreach (visited[i]) visited[i] = 1'b0;
			foreach (path[i]) path[i] = 0;
			depth = 1;
			here = 0;
			side_reg = mbs_pkg::side_t'(mbs_pkg::SIDE_RESET);
			errors = 0;
		endfunction

		function bit is_free(int r, int c);
			return !visited[(r * mbs_pkg::MAX_SIDE + c) % mbs_pkg::CELLS];
		endfunction

		function void note_step(word_t w);
			int n, r, c, cnt, k;
			int cr[mbs_pkg::NBR];
			int cc[mbs_pkg::NBR];
			mbs_pkg::dir_t cd[mbs_pkg::NBR];
			walk_beat_t e;
			n = (side_reg == 0) ? 1 : (int'(side_reg) > mbs_pkg::MAX_SIDE) ?
				mbs_pkg::MAX_SIDE : int'(side_reg);
			r = here / mbs_pkg::MAX_SIDE;
			c = here % mbs_pkg::MAX_SIDE;
			e = '0;
			cnt = 0;
			if (depth == 0) begin
				e.finished = 1'b1;
			end else begin
				visited[here] = 1'b1;
				if (r > 0 && r - 1 < n && c < n && is_free(r - 1, c)) begin
					cr[cnt] = r - 1; cc[cnt] = c; cd[cnt] = mbs_pkg::DIR_UP; cnt++;
				end
				if (r + 1 < n && c < n && is_free(r + 1, c)) begin
					cr[cnt] = r + 1; cc[cnt] = c; cd[cnt] = mbs_pkg::DIR_DOWN; cnt++;
				end
				if (c > 0 && c - 1 < n && r < n && is_free(r, c - 1)) begin
					cr[cnt] = r; cc[cnt] = c - 1; cd[cnt] = mbs_pkg::DIR_LEFT; cnt++;
				end
				if (c + 1 < n && r < n && is_free(r, c + 1)) begin
					cr[cnt] = r; cc[cnt] = c + 1; cd[cnt] = mbs_pkg::DIR_RIGHT; cnt++;
				end
				if (cnt > 0) begin
					k = int'(w) % cnt;
					if (depth < mbs_pkg::CELLS) begin
						path[depth] = here;
						depth++;
					end
					e.carved = 1'b1;
					e.carve_dir = cd[k];
					here = cr[k] * mbs_pkg::MAX_SIDE + cc[k];
				end else begin
					depth--;
					here = path[depth % mbs_pkg::CELLS] % mbs_pkg::CELLS;
				end
			end
			e.from_row = mbs_pkg::ocoord_t'(r);
			e.from_col = mbs_pkg::ocoord_t'(c);
			e.cur_row = mbs_pkg::ocoord_t'(here / mbs_pkg::MAX_SIDE);
			e.cur_col = mbs_pkg::ocoord_t'(here % mbs_pkg::MAX_SIDE);
			pending = {pending, e};
		endfunction

		task report(string what, int got, int want);
			$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check(walk_beat_t got);
			walk_beat_t e;
			if (pending.size() == 0) begin
				report("result beat with nothing pending, finished", got.finished, 0);
				return;
			end
			e = pending.pop_front();
			if (got.finished !== e.finished) report("finished", got.finished, e.finished);
			if (got.carved !== e.carved) report("carved", got.carved, e.carved);
			if (got.from_row !== e.from_row) report("from_row", got.from_row, e.from_row);
			if (got.from_col !== e.from_col) report("from_col", got.from_col, e.from_col);
			if (got.carve_dir !== e.carve_dir) report("carve_dir", got.carve_dir, e.carve_dir);
			if (got.cur_row !== e.cur_row) report("cur_row", got.cur_row, e.cur_row);
			if (got.cur_col !== e.cur_col) report("cur_col", got.cur_col, e.cur_col);
		endtask
	endclass

	logic clk;
	logic arst_n;

	mbs_cfg_if  cfg_bus ();
	mbs_rand_if step_bus ();
	mbs_res_if  res_bus ();

	maze_backtracker_step dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.step   (step_bus),
		.result (res_bus)
	);

	maze_walk_board board = new();
	bit             no_idle;
	int             hold_cnt;
	int             next_hold;
	int             idle_cycles;
	walk_beat_t     seen;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int gap_len();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result sink with random back-pressure
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			seen.finished = res_bus.finished;
			seen.carved = res_bus.carved;
			seen.from_row = res_bus.from_row;
			seen.from_col = res_bus.from_col;
			seen.carve_dir = res_bus.carve_dir;
			seen.cur_row = res_bus.cur_row;
			seen.cur_col = res_bus.cur_col;
			board.check(seen);
			next_hold = gap_len();
			hold_cnt <= next_hold;
			res_bus.ready <= (next_hold == 0);
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			res_bus.ready <= (hold_cnt == 1);
		end
	end

	always @(posedge clk) begin
		if ((cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1) ||
			(step_bus.valid === 1'b1 && step_bus.ready === 1'b1) ||
			(res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_step(input word_t w);
		int g;
		g = gap_len();
		if (g > 0) begin
			step_bus.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		step_bus.valid <= 1'b1;
		step_bus.random <= w;
		@(posedge clk);
		while (step_bus.ready !== 1'b1) @(posedge clk);
		board.note_step(w);
	endtask

	// wait until every pending result has come back, then let the walker settle
	task automatic settle();
		step_bus.valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_side(input mbs_pkg::side_t s);
		cfg_bus.valid <= 1'b1;
		cfg_bus.side <= s;
		@(posedge clk);
		while (cfg_bus.ready !== 1'b1) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		board.side_reg = s;
	endtask

	task automatic random_walk(input mbs_pkg::side_t s, input int count, input bit pause_mid);
		settle();
		write_side(s);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
			if (pause_mid && i == count / 2) settle();
			if ($urandom_range(0, 7) == 0) send_step(word_t'($urandom_range(0, 7)));
			else send_step(word_t'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		word_t words[12];
		words = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
			16'hAAAA, 16'h5555, 16'h0002, 16'h0003, 16'h7FFF, 16'hFFFE,
			16'hFFFF, 16'h0000};
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.side = '0;
		step_bus.valid = 1'b0;
		step_bus.random = '0;
		res_bus.ready = 1'b1;
		no_idle = 1'b0;
		hold_cnt = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small grids first: carves, dead ends, then a cell left outside the grid
		write_side(mbs_pkg::side_t'(2));
		for (int i = 0; i < 4; i++) send_step(words[i]);
		settle();
		write_side(mbs_pkg::side_t'(3));
		for (int i = 4; i < 10; i++) send_step(words[i]);
		settle();
		write_side(mbs_pkg::side_t'(0));
		for (int i = 10; i < 12; i++) send_step(words[i]);

		random_walk(mbs_pkg::side_t'(64), 400, 1'b1);
		random_walk(mbs_pkg::side_t'(127), 300, 1'b0);
		random_walk(mbs_pkg::side_t'(33), 100, 1'b0);
		random_walk(mbs_pkg::side_t'(100), 300, 1'b1);

		// unwind the whole path, then a few beats past the end of the walk
		settle();
		write_side(mbs_pkg::side_t'(0));
		no_idle = 1'b0;
		while (board.depth != 0) send_step(word_t'($urandom_range(0, 65535)));
		for (int i = 0; i < 10; i++) send_step(word_t'($urandom_range(0, 65535)));
		settle();

		if (board.pending.size() != 0)
			board.report("results still pending", board.pending.size(), 0);
		if (board.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
